// ===== design/svpwm_pkg.sv =====
`default_nettype none

package svpwm_pkg;

    localparam int TURN_BITS = 24;
    localparam int GUARD     = 6;
    localparam int STEPS     = 20;
    localparam int DIV_STEPS = 16;
    localparam int IDX_BITS  = 16;
    localparam int ROT_W     = 33;
    localparam int ROT_ZW    = TURN_BITS + 1;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    typedef logic [TURN_BITS-1:0] t_turn;

    localparam t_turn TURN_QUARTER  = 24'h400000;
    localparam t_turn TURN_3QUARTER = 24'hC00000;
    localparam t_turn TURN_HALF     = 24'h800000;

    localparam t_turn ATAN_TURNS [STEPS] = '{
        24'd2097152, 24'd1238021, 24'd654136, 24'd332050, 24'd166669,
        24'd83416,   24'd41718,   24'd20860,  24'd10430,  24'd5215,
        24'd2608,    24'd1304,    24'd652,    24'd326,    24'd163,
        24'd81,      24'd41,      24'd20,     24'd10,     24'd5
    };

    localparam logic [15:0] KINV_HI = 16'h9B74;
    localparam logic [15:0] KINV_LO = 16'hEDA8;
    localparam logic signed [ROT_W-1:0] KINV_Q30 = 33'sd652032874;
    localparam logic [30:0] SQRT3_Q30 = 31'd1859775393;
    localparam logic [30:0] ONE_Q30   = 31'h40000000;

    localparam logic [ROT_ZW-1:0] SECT_LO [6] = '{
        25'd0, 25'd2796203, 25'd5592406, 25'd8388608, 25'd11184811, 25'd13981014
    };
    localparam logic [ROT_ZW-1:0] SECT_HI [6] = '{
        25'd2796202, 25'd5592405, 25'd8388608, 25'd11184810, 25'd13981013, 25'd16777216
    };

    localparam logic [2:0] SEC_0 = 3'd0;
    localparam logic [2:0] SEC_1 = 3'd1;
    localparam logic [2:0] SEC_2 = 3'd2;
    localparam logic [2:0] SEC_3 = 3'd3;
    localparam logic [2:0] SEC_4 = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_SUPPLY   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND = 3'd3;

    typedef struct packed {
        t_turn ang;
        logic  dead;
        logic  qpos;
    } t_vec_side;

    typedef struct packed {
        logic [2:0]  sec;
        logic        sat;
        logic [14:0] rem;
        logic [15:0] num;
        logic [15:0] quo;
    } t_rot_side;

endpackage

`default_nettype wire

// ===== design/svpwm_vec_cell.sv =====
`default_nettype none

module svpwm_vec_cell #(
    parameter int XW   = 25,
    parameter int STEP = 0
) (
    input  wire                      i_clk,
    input  wire                      i_en,
    input  wire logic signed [XW-1:0] i_x,
    input  wire logic signed [XW-1:0] i_y,
    input  wire svpwm_pkg::t_turn     i_z,
    input  wire svpwm_pkg::t_vec_side i_side,
    output logic signed [XW-1:0]      o_x,
    output logic signed [XW-1:0]      o_y,
    output svpwm_pkg::t_turn          o_z,
    output svpwm_pkg::t_vec_side      o_side
);

    logic signed [XW-1:0] dx, dy, n_x, n_y;
    svpwm_pkg::t_turn     n_z;

    always_comb begin
        dx  = i_y >>> STEP;
        dy  = i_x >>> STEP;
        n_x = i_x;
        n_y = i_y;
        n_z = i_z;
        if (i_y > 0) begin
            n_x = i_x + dx;
            n_y = i_y - dy;
            n_z = i_z + svpwm_pkg::ATAN_TURNS[STEP];
        end else if (i_y < 0) begin
            n_x = i_x - dx;
            n_y = i_y + dy;
            n_z = i_z - svpwm_pkg::ATAN_TURNS[STEP];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_x    <= n_x;
            o_y    <= n_y;
            o_z    <= n_z;
            o_side <= i_side;
        end
    end

endmodule

`default_nettype wire

// ===== design/svpwm_rot_cell.sv =====
`default_nettype none

module svpwm_rot_cell #(
    parameter int STEP = 0
) (
    input  wire                      i_clk,
    input  wire                      i_en,
    input  wire logic [14:0]         i_supply,
    input  wire logic signed [svpwm_pkg::ROT_W-1:0]  i_x1,
    input  wire logic signed [svpwm_pkg::ROT_W-1:0]  i_y1,
    input  wire logic signed [svpwm_pkg::ROT_ZW-1:0] i_z1,
    input  wire logic signed [svpwm_pkg::ROT_W-1:0]  i_x2,
    input  wire logic signed [svpwm_pkg::ROT_W-1:0]  i_y2,
    input  wire logic signed [svpwm_pkg::ROT_ZW-1:0] i_z2,
    input  wire svpwm_pkg::t_rot_side i_side,
    output logic signed [svpwm_pkg::ROT_W-1:0]  o_x1,
    output logic signed [svpwm_pkg::ROT_W-1:0]  o_y1,
    output logic signed [svpwm_pkg::ROT_ZW-1:0] o_z1,
    output logic signed [svpwm_pkg::ROT_W-1:0]  o_x2,
    output logic signed [svpwm_pkg::ROT_W-1:0]  o_y2,
    output logic signed [svpwm_pkg::ROT_ZW-1:0] o_z2,
    output svpwm_pkg::t_rot_side o_side
);

    logic signed [svpwm_pkg::ROT_ZW-1:0] atan;
    logic signed [svpwm_pkg::ROT_W-1:0]  n_x1, n_y1, n_x2, n_y2;
    logic signed [svpwm_pkg::ROT_ZW-1:0] n_z1, n_z2;
    logic [15:0]                         trial;
    svpwm_pkg::t_rot_side                n_side;

    always_comb begin
        atan = signed'(svpwm_pkg::ROT_ZW'(svpwm_pkg::ATAN_TURNS[STEP]));
        if (i_z1 >= 0) begin
            n_x1 = i_x1 - (i_y1 >>> STEP);
            n_y1 = i_y1 + (i_x1 >>> STEP);
            n_z1 = i_z1 - atan;
        end else begin
            n_x1 = i_x1 + (i_y1 >>> STEP);
            n_y1 = i_y1 - (i_x1 >>> STEP);
            n_z1 = i_z1 + atan;
        end
        if (i_z2 >= 0) begin
            n_x2 = i_x2 - (i_y2 >>> STEP);
            n_y2 = i_y2 + (i_x2 >>> STEP);
            n_z2 = i_z2 - atan;
        end else begin
            n_x2 = i_x2 + (i_y2 >>> STEP);
            n_y2 = i_y2 - (i_x2 >>> STEP);
            n_z2 = i_z2 + atan;
        end
    end

    // One quotient bit of the modulation index per cell, in the leading cells only.
    always_comb begin
        n_side = i_side;
        trial  = {i_side.rem, i_side.num[15]};
        if (STEP < svpwm_pkg::DIV_STEPS) begin
            n_side.num = {i_side.num[14:0], 1'b0};
            if (trial >= {1'b0, i_supply}) begin
                n_side.rem = 15'(trial - {1'b0, i_supply});
                n_side.quo = {i_side.quo[14:0], 1'b1};
            end else begin
                n_side.rem = trial[14:0];
                n_side.quo = {i_side.quo[14:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_x1   <= n_x1;
            o_y1   <= n_y1;
            o_z1   <= n_z1;
            o_x2   <= n_x2;
            o_y2   <= n_y2;
            o_z2   <= n_z2;
            o_side <= n_side;
        end
    end

endmodule

`default_nettype wire

// ===== design/svpwm_duty_from_dq_voltage.sv =====
// Throughput: one item per cycle while the output does not stall; each of the 47
// pipeline stages holds one item. A stalled output lets empty stages upstream fill,
// so input stalls only when all are full.
// Reset (synchronous, active low) empties the pipeline and loads the register defaults.
`default_nettype none

module svpwm_duty_from_dq_voltage #(
    parameter int ANGLE_BITS = 16,
    parameter int VOLT_BITS  = 16
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_valid,
    output logic                    o_stall,
    input  wire logic signed [VOLT_BITS-1:0] i_volt_q,
    input  wire logic signed [VOLT_BITS-1:0] i_volt_d,
    input  wire logic [ANGLE_BITS-1:0]       i_elec_angle,
    output logic                    o_valid,
    input  wire                     i_stall,
    output logic [15:0]             o_compare_a,
    output logic [15:0]             o_compare_b,
    output logic [15:0]             o_compare_c,
    output logic [2:0]              o_sector_number,
    input  wire                     i_cfg_we,
    input  wire logic [svpwm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [svpwm_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int STEPS  = svpwm_pkg::STEPS;
    localparam int XW     = VOLT_BITS + svpwm_pkg::GUARD + 3;
    localparam int DW     = VOLT_BITS + 2;
    localparam int RW     = svpwm_pkg::ROT_W;
    localparam int ZW     = svpwm_pkg::ROT_ZW;
    localparam int ST_M1  = STEPS + 1;
    localparam int ST_M2  = STEPS + 2;
    localparam int ST_R0  = STEPS + 3;
    localparam int ST_P1  = 2 * STEPS + 3;
    localparam int ST_P2  = 2 * STEPS + 4;
    localparam int ST_P3  = 2 * STEPS + 5;
    localparam int NST    = 2 * STEPS + 7;

    logic [14:0] r_supply;
    logic [15:0] r_limit;
    logic [15:0] r_period;
    logic [9:0]  r_dead_band;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_supply    <= 15'd24576;
            r_limit     <= 16'd26214;
            r_period    <= 16'd3500;
            r_dead_band <= 10'd10;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                svpwm_pkg::REG_SUPPLY:   r_supply    <= i_cfg_data[14:0];
                svpwm_pkg::REG_LIMIT:    r_limit     <= i_cfg_data;
                svpwm_pkg::REG_PERIOD:   r_period    <= i_cfg_data;
                svpwm_pkg::REG_DEADBAND: r_dead_band <= i_cfg_data[9:0];
                default: ;
            endcase
        end
    end

    logic [NST-1:0] r_vld;
    logic [NST-1:0] en;

    assign en[NST-1] = !r_vld[NST-1] || !i_stall;
    for (genvar k = 0; k < NST - 1; k++) begin : g_en
        assign en[k] = !r_vld[k] || en[k+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_stall = !en[0];
    assign o_valid = r_vld[NST-1];

    // Input stage: fold the vector into the right half plane.
    logic signed [XW-1:0] uq_x, ud_x, n0_x, n0_y;
    logic signed [DW-1:0] ud_w, db_w;
    svpwm_pkg::t_turn     n0_z;
    svpwm_pkg::t_vec_side n0_side;

    logic signed [XW-1:0] vx [STEPS+1];
    logic signed [XW-1:0] vy [STEPS+1];
    svpwm_pkg::t_turn     vz [STEPS+1];
    svpwm_pkg::t_vec_side vs [STEPS+1];

    always_comb begin
        uq_x = XW'(i_volt_q);
        ud_x = XW'(i_volt_d);
        ud_w = DW'(i_volt_d);
        db_w = signed'(DW'(r_dead_band));
        if (i_volt_d < 0) begin
            n0_x = (-ud_x) <<< svpwm_pkg::GUARD;
            n0_y = (-uq_x) <<< svpwm_pkg::GUARD;
            n0_z = svpwm_pkg::TURN_HALF;
        end else begin
            n0_x = ud_x <<< svpwm_pkg::GUARD;
            n0_y = uq_x <<< svpwm_pkg::GUARD;
            n0_z = '0;
        end
        n0_side.ang  = svpwm_pkg::t_turn'(i_elec_angle)
                       << (svpwm_pkg::TURN_BITS - ANGLE_BITS);
        n0_side.dead = (ud_w > -db_w) && (ud_w < db_w);
        n0_side.qpos = i_volt_q > 0;
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            vx[0] <= n0_x;
            vy[0] <= n0_y;
            vz[0] <= n0_z;
            vs[0] <= n0_side;
        end
    end

    for (genvar k = 0; k < STEPS; k++) begin : g_vec
        svpwm_vec_cell #(
            .XW   (XW),
            .STEP (k)
        ) u_vec (
            .i_clk  (i_clk),
            .i_en   (en[k+1]),
            .i_x    (vx[k]),
            .i_y    (vy[k]),
            .i_z    (vz[k]),
            .i_side (vs[k]),
            .o_x    (vx[k+1]),
            .o_y    (vy[k+1]),
            .o_z    (vz[k+1]),
            .o_side (vs[k+1])
        );
    end

    // Gain correction partial products and the vector angle.
    logic [XW-2:0]    xc;
    svpwm_pkg::t_turn off;
    logic [XW+15:0]   r1_ph, r1_pl;
    svpwm_pkg::t_turn r1_theta;

    always_comb begin
        xc = (vx[STEPS] < 0) ? '0 : vx[STEPS][XW-2:0];
        if (vs[STEPS].dead) begin
            off = vs[STEPS].qpos ? svpwm_pkg::TURN_QUARTER : svpwm_pkg::TURN_3QUARTER;
        end else begin
            off = vz[STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[ST_M1]) begin
            r1_ph    <= (XW+16)'(xc) * (XW+16)'(svpwm_pkg::KINV_HI);
            r1_pl    <= (XW+16)'(xc) * (XW+16)'(svpwm_pkg::KINV_LO);
            r1_theta <= vs[STEPS].ang + off;
        end
    end

    // Magnitude, sector and the two sine angles.
    logic [XW+16:0] msum;
    logic [XW-1:0]  mag;
    logic [2:0]     sec;
    logic [ZW-1:0]  th_w;
    svpwm_pkg::t_rot_side n2_side;

    logic signed [RW-1:0] rx1 [STEPS+1];
    logic signed [RW-1:0] ry1 [STEPS+1];
    logic signed [ZW-1:0] rz1 [STEPS+1];
    logic signed [RW-1:0] rx2 [STEPS+1];
    logic signed [RW-1:0] ry2 [STEPS+1];
    logic signed [ZW-1:0] rz2 [STEPS+1];
    svpwm_pkg::t_rot_side rs  [STEPS+1];

    always_comb begin
        msum = (XW+17)'(r1_ph) + (XW+17)'(r1_pl >> 16);
        mag  = XW'(msum >> 16);
        th_w = ZW'(r1_theta);
        sec  = svpwm_pkg::SEC_0;
        for (int k = 1; k < 6; k++) begin
            if (th_w >= svpwm_pkg::SECT_LO[k]) begin
                sec = 3'(k);
            end
        end
        n2_side.sec = sec;
        n2_side.sat = mag >= (XW'(r_supply) << svpwm_pkg::GUARD);
        n2_side.rem = mag[svpwm_pkg::GUARD+14:svpwm_pkg::GUARD];
        n2_side.num = 16'(mag[svpwm_pkg::GUARD-1:0]) << (16 - svpwm_pkg::GUARD);
        n2_side.quo = '0;
    end

    always_ff @(posedge i_clk) begin
        if (en[ST_M2]) begin
            rx1[0] <= svpwm_pkg::KINV_Q30;
            ry1[0] <= '0;
            rz1[0] <= signed'(svpwm_pkg::SECT_HI[sec] - th_w);
            rx2[0] <= svpwm_pkg::KINV_Q30;
            ry2[0] <= '0;
            rz2[0] <= signed'(th_w - svpwm_pkg::SECT_LO[sec]);
            rs[0]  <= n2_side;
        end
    end

    for (genvar k = 0; k < STEPS; k++) begin : g_rot
        svpwm_rot_cell #(
            .STEP (k)
        ) u_rot (
            .i_clk    (i_clk),
            .i_en     (en[ST_R0+k]),
            .i_supply (r_supply),
            .i_x1     (rx1[k]),
            .i_y1     (ry1[k]),
            .i_z1     (rz1[k]),
            .i_x2     (rx2[k]),
            .i_y2     (ry2[k]),
            .i_z2     (rz2[k]),
            .i_side   (rs[k]),
            .o_x1     (rx1[k+1]),
            .o_y1     (ry1[k+1]),
            .o_z1     (rz1[k+1]),
            .o_x2     (rx2[k+1]),
            .o_y2     (ry2[k+1]),
            .o_z2     (rz2[k+1]),
            .o_side   (rs[k+1])
        );
    end

    // Clamp the sines, scale by the square root of three and limit the modulation index.
    logic [30:0] sin1, sin2;
    logic [61:0] sp1, sp2;
    logic [15:0] idx;
    logic [30:0] r3_p1, r3_p2;
    logic [15:0] r3_idx;
    logic [2:0]  r3_sec;

    always_comb begin
        if (ry1[STEPS] < 0) begin
            sin1 = '0;
        end else if (ry1[STEPS] > signed'(RW'(svpwm_pkg::ONE_Q30))) begin
            sin1 = svpwm_pkg::ONE_Q30;
        end else begin
            sin1 = ry1[STEPS][30:0];
        end
        if (ry2[STEPS] < 0) begin
            sin2 = '0;
        end else if (ry2[STEPS] > signed'(RW'(svpwm_pkg::ONE_Q30))) begin
            sin2 = svpwm_pkg::ONE_Q30;
        end else begin
            sin2 = ry2[STEPS][30:0];
        end
        sp1 = 62'(sin1) * 62'(svpwm_pkg::SQRT3_Q30);
        sp2 = 62'(sin2) * 62'(svpwm_pkg::SQRT3_Q30);
        if (rs[STEPS].sat || rs[STEPS].quo > r_limit) begin
            idx = r_limit;
        end else begin
            idx = rs[STEPS].quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[ST_P1]) begin
            r3_p1  <= sp1[60:30];
            r3_p2  <= sp2[60:30];
            r3_idx <= idx;
            r3_sec <= rs[STEPS].sec;
        end
    end

    // Active times.
    logic [46:0] tp1, tp2;
    logic [16:0] r4_t1, r4_t2;
    logic [2:0]  r4_sec;

    always_comb begin
        tp1 = 47'(r3_p1) * 47'(r3_idx);
        tp2 = 47'(r3_p2) * 47'(r3_idx);
    end

    always_ff @(posedge i_clk) begin
        if (en[ST_P2]) begin
            r4_t1  <= tp1[46:30];
            r4_t2  <= tp2[46:30];
            r4_sec <= r3_sec;
        end
    end

    // Duties in Q17, placed by sector.
    logic signed [19:0] t1_w, t2_w, lo, d_1, d_2, d_12, n5_a, n5_b, n5_c;
    logic signed [19:0] r5_a, r5_b, r5_c;
    logic [2:0]         r5_sec;

    always_comb begin
        t1_w = signed'(20'(r4_t1));
        t2_w = signed'(20'(r4_t2));
        lo   = 20'sd65536 - t1_w - t2_w;
        d_1  = lo + (t1_w <<< 1);
        d_2  = lo + (t2_w <<< 1);
        d_12 = lo + ((t1_w + t2_w) <<< 1);
        unique case (r4_sec)
            svpwm_pkg::SEC_0: begin n5_a = lo;   n5_b = d_1;  n5_c = d_12; end
            svpwm_pkg::SEC_1: begin n5_a = d_2;  n5_b = lo;   n5_c = d_12; end
            svpwm_pkg::SEC_2: begin n5_a = d_12; n5_b = lo;   n5_c = d_1;  end
            svpwm_pkg::SEC_3: begin n5_a = d_12; n5_b = d_2;  n5_c = lo;   end
            svpwm_pkg::SEC_4: begin n5_a = d_1;  n5_b = d_12; n5_c = lo;   end
            default:          begin n5_a = lo;   n5_b = d_12; n5_c = d_2;  end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en[ST_P3]) begin
            r5_a   <= n5_a;
            r5_b   <= n5_b;
            r5_c   <= n5_c;
            r5_sec <= r4_sec;
        end
    end

    // Compare counts, saturated to the timer range.
    logic [34:0] cp_a, cp_b, cp_c;
    logic [15:0] n_cmp_a, n_cmp_b, n_cmp_c;

    always_comb begin
        cp_a = 35'(r5_a[18:0]) * 35'(r_period);
        cp_b = 35'(r5_b[18:0]) * 35'(r_period);
        cp_c = 35'(r5_c[18:0]) * 35'(r_period);
        if (r5_a <= 0)               n_cmp_a = '0;
        else if (cp_a[34:33] != '0)  n_cmp_a = 16'hFFFF;
        else                         n_cmp_a = cp_a[32:17];
        if (r5_b <= 0)               n_cmp_b = '0;
        else if (cp_b[34:33] != '0)  n_cmp_b = 16'hFFFF;
        else                         n_cmp_b = cp_b[32:17];
        if (r5_c <= 0)               n_cmp_c = '0;
        else if (cp_c[34:33] != '0)  n_cmp_c = 16'hFFFF;
        else                         n_cmp_c = cp_c[32:17];
    end

    always_ff @(posedge i_clk) begin
        if (en[NST-1]) begin
            o_compare_a     <= n_cmp_a;
            o_compare_b     <= n_cmp_b;
            o_compare_c     <= n_cmp_c;
            o_sector_number <= r5_sec + 3'd1;
        end
    end

    a_sector_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_sector_number >= 3'd1 && o_sector_number <= 3'd6))
        else $error("Sector number out of range.");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> ((&r_vld) && i_stall))
        else $error("Input stalled while the pipeline has room.");

    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_vld[0])
        else $error("Accepted transfer did not enter the first stage.");

endmodule

`default_nettype wire
